// ----- src/ffba_pkg.sv -----
// ffba_pkg: shared types and constants for the first-fit block allocator.
// Used by ffba_cell and first_fit_block_allocator; depends on nothing.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int SIZE_W = 16;  // block size / request size
  localparam int IDX_W  = 4;   // block index field
  localparam int CNT_W  = 5;   // block_count register

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

  // tuser codes on the input channel
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_REQ  = 1'b1;

  // register index, taken from cfg_paddr[2]
  localparam logic REG_BLOCK_COUNT = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_PEND
  } state_t;

  // load broadcast to every cell
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] data;
  } load_t;

  // request token walking down the chain
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [IDX_W-1:0]  pick;
    logic [SIZE_W-1:0] size;
  } tok_t;

endpackage

// ----- src/ffba_cell.sv -----
// ffba_cell: one table entry of the allocator chain plus one token stage.
// Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ffba_pkg::CNT_W-1:0]  limit,
  input  ffba_pkg::load_t             ld,
  input  ffba_pkg::tok_t              tok_in,
  output ffba_pkg::tok_t              tok_out
);

  localparam logic [8:0] POS      = 9'(IDX);
  // only cells reachable by a block_index field can be loaded
  localparam bit         LOADABLE = (IDX < (1 << ffba_pkg::IDX_W));

  logic [ffba_pkg::SIZE_W-1:0] rem_r, rem_nxt;
  ffba_pkg::tok_t              tok_r, tok_nxt;
  logic                        in_range;
  logic                        fit;
  logic                        ld_hit;

  assign in_range = POS < 9'(limit);
  assign fit      = tok_in.vld && !tok_in.hit && in_range && (rem_r >= tok_in.size);
  assign ld_hit   = LOADABLE && ld.we && (ld.idx == POS[ffba_pkg::IDX_W-1:0]);

  always_comb begin
    tok_nxt = tok_in;
    rem_nxt = rem_r;
    if (fit) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.pick = POS[ffba_pkg::IDX_W-1:0];
      rem_nxt      = rem_r - tok_in.size;
    end
    if (ld_hit) begin
      rem_nxt = ld.data;
    end
  end

  // entry has no reset: contents are undefined until loaded
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- src/first_fit_block_allocator.sv -----
// first_fit_block_allocator: top level, config register, control and cell chain.
// Depends on ffba_pkg and ffba_cell.
`timescale 1ns / 1ps

// First-fit allocator over a table of MAX_BLOCKS free sizes. Each table entry
// lives in its own cell; cells form a chain. A load word (tuser = 0) writes one
// entry and returns nothing; indexes at or above MAX_BLOCKS are dropped. A
// request word (tuser = 1) launches a token into cell 0 that moves one cell
// per clock; the first cell below block_count whose remaining size covers the
// request claims it, subtracts the size and marks the token. A request keeps
// the block busy until its token leaves the last cell; loads are taken
// back to back. in_tready is low while a token is in the chain and while a
// result is parked. The result sits in an output register, so the next word is
// taken while a result still waits; a second result that finds the output full
// parks in a holding register until the first is taken. block_count (APB, byte
// address 0) must only be written while idle. Entries never loaded read as
// undefined.

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // APB config
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] block_index, [19:4] size, [23:20] zero
  input  logic        in_tuser,   // [0] cmd
  input  logic        in_tlast,   // last_request
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] chosen_block, [7:4] zero
  output logic        out_tuser,  // [0] granted
  output logic        out_tlast   // is_last
);

  localparam int IW = ffba_pkg::IDX_W;

  // ---------------- config register ----------------
  logic [ffba_pkg::CNT_W-1:0] block_count_r;
  logic                       cfg_wr;
  logic                       cfg_sel_bc;

  assign cfg_pready = 1'b1;
  assign cfg_sel_bc = (cfg_paddr[2] == ffba_pkg::REG_BLOCK_COUNT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_bc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= ffba_pkg::BLOCK_COUNT_RST;
    end else if (cfg_wr) begin
      block_count_r <= cfg_pwdata[ffba_pkg::CNT_W-1:0];
    end
  end

  assign cfg_prdata = cfg_sel_bc ? {{(32-ffba_pkg::CNT_W){1'b0}}, block_count_r} : 32'd0;

  // ---------------- input decode ----------------
  ffba_pkg::state_t state_r, state_nxt;
  logic             in_acc;
  ffba_pkg::load_t  ld;
  ffba_pkg::tok_t   tok_w [MAX_BLOCKS+1];
  logic [MAX_BLOCKS:0] tok_vld;

  assign in_tready = (state_r == ffba_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign ld.we   = in_acc && (in_tuser == ffba_pkg::CMD_LOAD);
  assign ld.idx  = in_tdata[IW-1:0];
  assign ld.data = in_tdata[IW+ffba_pkg::SIZE_W-1:IW];

  // request token enters cell 0 on acceptance
  assign tok_w[0].vld  = in_acc && (in_tuser == ffba_pkg::CMD_REQ);
  assign tok_w[0].hit  = 1'b0;
  assign tok_w[0].pick = '0;
  assign tok_w[0].size = in_tdata[IW+ffba_pkg::SIZE_W-1:IW];

  // ---------------- cell chain ----------------
  genvar g;
  generate
    for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      ffba_cell #(.IDX(g)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .limit   (block_count_r),
        .ld      (ld),
        .tok_in  (tok_w[g]),
        .tok_out (tok_w[g+1])
      );
    end
    for (g = 0; g <= MAX_BLOCKS; g++) begin : g_vld
      assign tok_vld[g] = tok_w[g].vld;
    end
  endgenerate

  // ---------------- control and result path ----------------
  logic          last_r, last_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic          out_grant_r, out_grant_nxt;
  logic [IW-1:0] out_pick_r, out_pick_nxt;
  logic          out_last_r, out_last_nxt;
  logic          pend_grant_r, pend_grant_nxt;
  logic [IW-1:0] pend_pick_r, pend_pick_nxt;
  logic          pend_last_r, pend_last_nxt;
  ffba_pkg::tok_t tok_end;

  assign tok_end = tok_w[MAX_BLOCKS];

  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    out_vld_nxt    = out_vld_r;
    out_grant_nxt  = out_grant_r;
    out_pick_nxt   = out_pick_r;
    out_last_nxt   = out_last_r;
    pend_grant_nxt = pend_grant_r;
    pend_pick_nxt  = pend_pick_r;
    pend_last_nxt  = pend_last_r;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ffba_pkg::S_IDLE: begin
        if (tok_w[0].vld) begin
          last_nxt  = in_tlast;
          state_nxt = ffba_pkg::S_RUN;
        end
      end
      ffba_pkg::S_RUN: begin
        if (tok_end.vld) begin
          if (!out_vld_r || out_tready) begin
            out_vld_nxt   = 1'b1;
            out_grant_nxt = tok_end.hit;
            out_pick_nxt  = tok_end.hit ? tok_end.pick : '0;
            out_last_nxt  = last_r;
            state_nxt     = ffba_pkg::S_IDLE;
          end else begin
            pend_grant_nxt = tok_end.hit;
            pend_pick_nxt  = tok_end.hit ? tok_end.pick : '0;
            pend_last_nxt  = last_r;
            state_nxt      = ffba_pkg::S_PEND;
          end
        end
      end
      ffba_pkg::S_PEND: begin
        // output register is full here; refill it as it drains
        if (out_tready) begin
          out_vld_nxt   = 1'b1;
          out_grant_nxt = pend_grant_r;
          out_pick_nxt  = pend_pick_r;
          out_last_nxt  = pend_last_r;
          state_nxt     = ffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ffba_pkg::S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r       <= last_nxt;
    out_grant_r  <= out_grant_nxt;
    out_pick_r   <= out_pick_nxt;
    out_last_r   <= out_last_nxt;
    pend_grant_r <= pend_grant_nxt;
    pend_pick_r  <= pend_pick_nxt;
    pend_last_r  <= pend_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(8-IW){1'b0}}, out_pick_r};
  assign out_tuser  = out_grant_r;
  assign out_tlast  = out_last_r;

  // ---------------- assertions ----------------
  // only one request in flight anywhere in the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld) <= 1)
    else $error("more than one request token in the chain");

  // a token leaves the chain only while control waits for it
  a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.vld |-> (state_r == ffba_pkg::S_RUN))
    else $error("token left chain outside RUN");

  // holding register is used only behind a full output register
  a_pend_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffba_pkg::S_PEND) |-> out_vld_r)
    else $error("PEND with empty output register");

  // a refused request reports block zero
  a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 8'd0))
    else $error("not-granted result with nonzero block");

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking bench for first_fit_block_allocator.
// Drives load/request words and the block_count register, predicts every grant.
// Depends on ffba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_BLOCKS = 16;
  localparam int PHASE_WORDS = 230;     // random words per block_count setting
  localparam int DRAIN_CYCLES = MAX_BLOCKS + 4;
  localparam int HOLD_CYCLES = 400;     // long sink stall, fills output + holding reg
  localparam int IDX_W = ffba_pkg::IDX_W;
  localparam int SIZE_W = ffba_pkg::SIZE_W;
  localparam int CNT_W = ffba_pkg::CNT_W;

  // one result word
  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] block;
    logic             last;
  } grant_t;

  // directed row; typed = 1 means the expected grant is written in the row
  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
    logic              last;
    logic              typed;
    logic              granted;
    logic [IDX_W-1:0]  block;
  } row_t;

  // Every entry is loaded before the first request so no unwritten entry is
  // ever scanned. Entry 15 holds the only full-scale size.
  localparam row_t DIR_TAB [0:23] = '{
    '{ffba_pkg::CMD_LOAD, 4'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd1,  16'd100,  1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd2,  16'h5555, 1'b1, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd3,  16'hAAAA, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd4,  16'h0001, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd5,  16'h8000, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd6,  16'h7FFF, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd7,  16'h00FF, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd8,  16'hFF00, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd9,  16'h1234, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd10, 16'hFFFE, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd11, 16'h0F0F, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd12, 16'hF0F0, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd13, 16'h3C3C, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd14, 16'hC3C3, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_LOAD, 4'd15, 16'hFFFF, 1'b1, 1'b0, 1'b0, 4'd0},
    // zero-size request lands on block 0 and leaves it at zero
    '{ffba_pkg::CMD_REQ,  4'd0,  16'h0000, 1'b0, 1'b1, 1'b1, 4'd0},
    '{ffba_pkg::CMD_REQ,  4'd15, 16'hFFFF, 1'b1, 1'b1, 1'b1, 4'd15},
    // block 15 now empty, nothing else covers full scale
    '{ffba_pkg::CMD_REQ,  4'd7,  16'hFFFF, 1'b0, 1'b1, 1'b0, 4'd0},
    '{ffba_pkg::CMD_REQ,  4'd0,  16'd1,    1'b0, 1'b1, 1'b1, 4'd1},
    '{ffba_pkg::CMD_REQ,  4'd0,  16'hAAAA, 1'b0, 1'b1, 1'b1, 4'd3},
    '{ffba_pkg::CMD_REQ,  4'd9,  16'h5556, 1'b0, 1'b0, 1'b0, 4'd0},
    '{ffba_pkg::CMD_REQ,  4'd0,  16'd99,   1'b1, 1'b1, 1'b1, 4'd1},
    '{ffba_pkg::CMD_REQ,  4'd6,  16'h8000, 1'b1, 1'b0, 1'b0, 4'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [3:0] block_index, [19:4] size, [23:20] zero
  logic        in_tuser = 1'b0; // [0] cmd
  logic        in_tlast = 1'b0; // last_request
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [3:0] chosen_block, [7:4] zero
  logic        out_tuser;       // [0] granted
  logic        out_tlast;       // is_last

  // bench-side copy of the allocator state
  logic [SIZE_W-1:0] free_left [MAX_BLOCKS];
  logic [CNT_W-1:0]  blk_count;
  grant_t            grant_q [$];   // grants still owed by the block

  int errors = 0;
  bit idle_on = 1'b0;       // master switch for random idling, off in the last phase
  int in_gap_pct = 0;
  int out_gap_pct = 0;
  bit hold_out = 1'b0;      // one-shot request for the long sink stall

  first_fit_block_allocator #(.MAX_BLOCKS(MAX_BLOCKS)) u_dut (.*);

  always #4 clk = ~clk;

  // Watchdog. Worst case is roughly 1900 words, each with its busy time, input gap and
  // sink stall, with an 8 ns clock, under 1 ms; this is several times that.
  initial begin : watchdog
    #5_000_000;
    $display("first_fit_block_allocator verification failed");
    $finish;
  end

  // First fit over the first min(block_count, MAX_BLOCKS) entries. Count 0
  // scans nothing; counts above the table are clamped.
  function automatic grant_t first_fit_pick(input logic [SIZE_W-1:0] req_size,
                                            input logic last);
    grant_t g;
    int     lim;
    lim = (blk_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(blk_count);
    g = '{granted: 1'b0, block: '0, last: last};
    for (int j = 0; j < lim; j++) begin
      if (!g.granted && free_left[j] >= req_size) begin
        g.granted = 1'b1;
        g.block = j[IDX_W-1:0];
        free_left[j] = free_left[j] - req_size;
      end
    end
    return g;
  endfunction

  // Load sizes spread wide so requests hit and miss; request sizes mostly small.
  function automatic logic [SIZE_W-1:0] pick_size(input bit wide);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return SIZE_W'($urandom_range(0, 65535));
      default: return wide ? SIZE_W'($urandom_range(256, 8191))
                           : SIZE_W'($urandom_range(0, 511));
    endcase
  endfunction

  // Offer one word, hold it until taken, then update the prediction.
  task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic [SIZE_W-1:0] size, input logic last,
                           input logic typed, input grant_t typed_grant);
    grant_t g;
    if (idle_on && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {4'b0000, size, idx};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == ffba_pkg::CMD_LOAD) begin
      free_left[idx] = size;  // every 4-bit index is inside the table
    end else begin
      g = first_fit_pick(size, last);
      grant_q.push_back(typed ? typed_grant : g);
    end
  endtask

  // Wait until every grant is back, then idle before the next phase.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write then read-back of block_count; junk in the unused upper bits.
  task automatic write_block_count(input logic [CNT_W-1:0] val);
    logic [31:0] word;
    word = $urandom();
    word[CNT_W-1:0] = val;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {ffba_pkg::REG_BLOCK_COUNT, 2'b00};
    cfg_pwdata <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    blk_count = val;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[CNT_W-1:0] !== val) begin
      errors++;
      $display("%0t: block_count read-back expected %0d got %0d",
               $time, val, cfg_prdata[CNT_W-1:0]);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed batches: a few loads, then requests with the batch end
  // flagged on the final one. About one batch in ten is a random mix instead.
  task automatic run_batches(input int n_words);
    int sent;
    int n_load;
    int n_req;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 15)),
                    pick_size(1'($urandom_range(0, 1))), 1'($urandom_range(0, 1)),
                    1'b0, '0);
          sent++;
        end
      end else begin
        n_load = $urandom_range(0, 3);
        n_req = $urandom_range(1, 6);
        repeat (n_load) begin
          send_word(ffba_pkg::CMD_LOAD, IDX_W'($urandom_range(0, 15)), pick_size(1'b1),
                    1'b0, 1'b0, '0);
          sent++;
        end
        for (int r = 0; r < n_req; r++) begin
          // index is don't-care on requests, randomized anyway
          send_word(ffba_pkg::CMD_REQ, IDX_W'($urandom_range(0, 15)), pick_size(1'b0),
                    r == n_req - 1, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // Result sink: random stall bursts, plus one long hold on request.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 99) < out_gap_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result check against the oldest owed grant.
  always @(posedge clk) begin : grant_check
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (grant_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word granted=%0b block=%0d last=%0b",
                 $time, out_tuser, out_tdata[3:0], out_tlast);
      end else begin
        want = grant_q.pop_front();
        if (out_tuser !== want.granted) begin
          errors++;
          $display("%0t: granted expected %0b got %0b", $time, want.granted, out_tuser);
        end
        if (out_tdata[3:0] !== want.block) begin
          errors++;
          $display("%0t: chosen_block expected %0d got %0d",
                   $time, want.block, out_tdata[3:0]);
        end
        if (out_tlast !== want.last) begin
          errors++;
          $display("%0t: is_last expected %0b got %0b", $time, want.last, out_tlast);
        end
      end
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] counts [8];
    // zero count, single block, clamp at 31, full table, just past the table,
    // two random settings, and a plain one for the idle-free finish
    counts = '{5'd0, 5'd1, 5'd31, 5'd16, 5'd17,
               CNT_W'($urandom_range(2, 15)), CNT_W'($urandom_range(18, 30)), 5'd8};
    foreach (free_left[i]) free_left[i] = '0;
    blk_count = ffba_pkg::BLOCK_COUNT_RST;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on = 1'b1;
    in_gap_pct = 15;
    out_gap_pct = 15;
    foreach (DIR_TAB[i]) begin
      send_word(DIR_TAB[i].cmd, DIR_TAB[i].idx, DIR_TAB[i].size, DIR_TAB[i].last,
                DIR_TAB[i].typed,
                grant_t'{granted: DIR_TAB[i].granted, block: DIR_TAB[i].block,
                         last: DIR_TAB[i].last});
    end

    foreach (counts[p]) begin
      drain_results();
      write_block_count(counts[p]);
      // idle rates vary per phase; 0 gives back-to-back stretches
      in_gap_pct = $urandom_range(0, 3) * 10;
      out_gap_pct = $urandom_range(0, 3) * 10;
      if (p == 3) hold_out = 1'b1;  // full table active, so grants pile up
      if (p == 7) idle_on = 1'b0;
      run_batches(PHASE_WORDS);
    end

    drain_results();
    if (errors == 0) begin
      $display("first_fit_block_allocator verification clean");
    end else begin
      $display("first_fit_block_allocator verification failed");
    end
    $finish;
  end

endmodule
